>>> hdl/dhoat_pkg.sv
// Package for the double-hashing open-address hash table.
// Holds field widths, operation codes, slot marks and status codes.
// No dependencies.
package dhoat_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int MARK_W   = 2;
    localparam int SLOT_W   = MARK_W + KEY_W;

    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOKEY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

>>> hdl/dhoat_mod_unit.sv
// Remainder unit: key mod TABLE_SIZE and key mod (TABLE_SIZE - 1).
// Both remainders come from reciprocal multiplication on one shared multiplier
// under a five-step sequencer. Depends on dhoat_pkg.
module dhoat_mod_unit import dhoat_pkg::*; #(
    parameter int TABLE_SIZE = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [KEY_W-1:0]              i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem_home,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem_step
);

    localparam int IW      = $clog2(TABLE_SIZE);
    localparam int MUL_W   = KEY_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SHIFT_A = KEY_W + $clog2(TABLE_SIZE);
    localparam int SHIFT_B = KEY_W + $clog2(TABLE_SIZE - 1);
    localparam logic [63:0] RECIP_A_W =
        ((64'd1 << SHIFT_A) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
    localparam logic [63:0] RECIP_B_W =
        ((64'd1 << SHIFT_B) + 64'(TABLE_SIZE - 2)) / 64'(TABLE_SIZE - 1);
    localparam logic [MUL_W-1:0] RECIP_A = MUL_W'(RECIP_A_W);
    localparam logic [MUL_W-1:0] RECIP_B = MUL_W'(RECIP_B_W);
    localparam logic [MUL_W-1:0] DIV_A   = MUL_W'(TABLE_SIZE);
    localparam logic [MUL_W-1:0] DIV_B   = MUL_W'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        P_IDLE,
        P_RECIP_A,
        P_BACK_A,
        P_RECIP_B,
        P_BACK_B,
        P_SUB_B
    } t_phase;

    t_phase            r_phase;
    logic [KEY_W-1:0]  r_key;
    logic [PROD_W-1:0] r_prod;
    logic [IW-1:0]     r_rem_a;
    logic [IW-1:0]     r_rem_b;
    logic              r_done;
    logic [MUL_W-1:0]  quot_a;
    logic [MUL_W-1:0]  quot_b;
    logic [MUL_W-1:0]  mul_x;
    logic [MUL_W-1:0]  mul_y;
    logic [PROD_W-1:0] n_prod;
    logic [IW-1:0]     diff;

    always_comb begin
        quot_a = MUL_W'(r_prod >> SHIFT_A);
        quot_b = MUL_W'(r_prod >> SHIFT_B);
        mul_x  = {1'b0, r_key};
        mul_y  = RECIP_A;
        unique case (r_phase)
            P_BACK_A: begin
                mul_x = quot_a;
                mul_y = DIV_A;
            end
            P_RECIP_B: begin
                mul_y = RECIP_B;
            end
            P_BACK_B: begin
                mul_x = quot_b;
                mul_y = DIV_B;
            end
            default: begin
                mul_y = RECIP_A;
            end
        endcase
        n_prod = PROD_W'(mul_x) * PROD_W'(mul_y);
        diff   = r_key[IW-1:0] - r_prod[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == P_SUB_B);
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_key   <= i_key;
                        r_phase <= P_RECIP_A;
                    end
                end
                P_RECIP_A: begin
                    r_prod  <= n_prod;
                    r_phase <= P_BACK_A;
                end
                P_BACK_A: begin
                    r_prod  <= n_prod;
                    r_phase <= P_RECIP_B;
                end
                P_RECIP_B: begin
                    r_rem_a <= diff;
                    r_prod  <= n_prod;
                    r_phase <= P_BACK_B;
                end
                P_BACK_B: begin
                    r_prod  <= n_prod;
                    r_phase <= P_SUB_B;
                end
                P_SUB_B: begin
                    r_rem_b <= diff;
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_rem_home = r_rem_a;
    assign o_rem_step = r_rem_b;

endmodule

>>> hdl/double_hash_open_address_table_unit.sv
// Steps per item: hashing in the remainder unit, a slot read, 1 to TABLE_SIZE probes and
// posting the result, which waits while a held result is not taken; an unused kind skips to posting.
// Items are handled one at a time; the remainder unit uses one shared multiplier and the
// slot memory has a single read port.
// After reset a clearing pass marks all TABLE_SIZE slots empty, one per cycle,
// and no item is accepted until it ends. Depends on dhoat_pkg and dhoat_mod_unit.
module double_hash_open_address_table_unit import dhoat_pkg::*; #(
    parameter int TABLE_SIZE = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_echo_key
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam logic [IW:0]   SIZE_EXT  = (IW+1)'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [KIND_W-1:0]     r_kind;
    logic [KEY_W-1:0]      r_key;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_step;
    logic [IW-1:0]         r_probe;
    logic [STATUS_W-1:0]   r_res_status;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [KEY_W-1:0]      r_out_key;
    logic [SLOT_W-1:0]     r_mem [TABLE_SIZE];
    logic [SLOT_W-1:0]     r_rd_data;

    logic                  accept;
    logic                  mod_start;
    logic                  mod_done;
    logic [IW-1:0]         rem_home;
    logic [IW-1:0]         rem_step;
    logic [IW:0]           idx_sum;
    logic [IW:0]           idx_wrap;
    logic [IW-1:0]         idx_next;
    logic [MARK_W-1:0]     rd_mark;
    logic                  hit;
    logic                  is_insert;
    logic                  last_probe;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [SLOT_W-1:0]     mem_wdata;
    logic [IW-1:0]         mem_raddr;

    dhoat_mod_unit #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_key      (i_key),
        .o_done     (mod_done),
        .o_rem_home (rem_home),
        .o_rem_step (rem_step)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign accept     = i_valid && o_ready;
    assign mod_start  = accept && (i_kind == KIND_FIND || i_kind == KIND_INSERT ||
                                   i_kind == KIND_REMOVE);
    assign rd_mark    = r_rd_data[SLOT_W-1:KEY_W];
    assign hit        = (rd_mark == MARK_USED) && (r_rd_data[KEY_W-1:0] == r_key);
    assign is_insert  = (r_kind == KIND_INSERT);
    assign last_probe = (r_probe == LAST_SLOT);

    always_comb begin
        idx_sum  = {1'b0, r_idx} + {1'b0, r_step};
        idx_wrap = (idx_sum >= SIZE_EXT) ? idx_sum - SIZE_EXT : idx_sum;
        idx_next = idx_wrap[IW-1:0];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {MARK_USED, r_key};
        mem_raddr = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = {MARK_EMPTY, {KEY_W{1'b0}}};
            end
            S_CHECK: begin
                mem_raddr = idx_next;
                if (is_insert) begin
                    mem_we = !hit && (rd_mark != MARK_USED);
                end else if (r_kind == KIND_REMOVE) begin
                    mem_we    = hit;
                    mem_wdata = {MARK_DELETED, r_key};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= i_kind;
                        r_key  <= i_key;
                        if (mod_start) begin
                            r_state <= S_HASH;
                        end else begin
                            r_res_status <= ST_NOKEY;
                            r_state      <= S_FINISH;
                        end
                    end
                end
                S_HASH: begin
                    if (mod_done) begin
                        r_idx   <= rem_home;
                        r_step  <= rem_step + 1'b1;
                        r_probe <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (is_insert && hit) begin
                        r_res_status <= ST_DUP;
                        r_state      <= S_FINISH;
                    end else if (is_insert && rd_mark != MARK_USED) begin
                        r_res_status <= ST_INSERTED;
                        r_state      <= S_FINISH;
                    end else if (!is_insert && hit) begin
                        r_res_status <= ST_FOUND;
                        r_state      <= S_FINISH;
                    end else if (!is_insert && rd_mark == MARK_EMPTY) begin
                        r_res_status <= ST_NOKEY;
                        r_state      <= S_FINISH;
                    end else if (last_probe) begin
                        r_res_status <= is_insert ? ST_FULL : ST_NOKEY;
                        r_state      <= S_FINISH;
                    end else begin
                        r_idx   <= idx_next;
                        r_probe <= r_probe + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_key    <= (r_res_status == ST_FOUND) ? r_key : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_echo_key = r_out_key;

endmodule
